// ----- rtl/plidm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plidm_pkg
// shared types, codes and helpers of the positional list with running max
// ----------------------------------------------------------------------------
package plidm_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int DATA_W       = 32;
   localparam int SLOT_W       = 7;
   localparam int OP_W         = 2;
   localparam int REQ_TDATA_W  = 40;
   localparam int RSP_TDATA_W  = 80;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SUM,
      ST_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_req;
      logic exec;
      logic load_rsp;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic rsp_busy;
   } dp_status_type;

   // shift command into the cell chain
   typedef struct packed {
      logic              ins;
      logic              del;
      logic [SLOT_W-1:0] slot;
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

   // node of the max / read tree
   typedef struct packed {
      logic              vld;
      logic [DATA_W-1:0] maxv;
      logic [DATA_W-1:0] rdv;
   } node_type;

   function automatic node_type node_merge(input node_type a, input node_type b);
      node_type m;
      logic     take_a;
      take_a = a.vld && (!b.vld || ($signed(a.maxv) >= $signed(b.maxv)));
      m.vld  = a.vld | b.vld;
      m.maxv = take_a ? a.maxv : b.maxv;
      m.rdv  = a.rdv | b.rdv;
      return m;
   endfunction

endpackage

// ----- rtl/plidm_cells.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plidm_cells
// cell chain holding the list entries and the fill count
// ----------------------------------------------------------------------------
module plidm_cells #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  plidm_pkg::cell_cmd_type        cmd,
   output logic [plidm_pkg::DATA_W-1:0]   entries [CAPACITY],
   output logic [CW-1:0]                  count
);

   localparam int W = (CW > plidm_pkg::SLOT_W) ? CW : plidm_pkg::SLOT_W;

   logic [plidm_pkg::DATA_W-1:0] entries_ff [CAPACITY];
   logic [plidm_pkg::DATA_W-1:0] entries_in [CAPACITY];
   logic [CW-1:0]                count_ff;
   logic [CW-1:0]                count_in;
   logic [W-1:0]                 slot_w;

   assign slot_w = W'(cmd.slot);

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [W-1:0] IDX = W'(i);
      logic [plidm_pkg::DATA_W-1:0] lower;
      logic [plidm_pkg::DATA_W-1:0] upper;

      if (i > 0) begin : g_lo
         assign lower = entries_ff[i-1];
      end else begin : g_lo0
         assign lower = entries_ff[i];
      end

      if (i < CAPACITY - 1) begin : g_up
         assign upper = entries_ff[i+1];
      end else begin : g_upn
         assign upper = entries_ff[i];
      end

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (cmd.ins) begin
            if (IDX == slot_w) begin
               entries_in[i] = cmd.value;
            end else if (IDX > slot_w) begin
               entries_in[i] = lower;
            end
         end else if (cmd.del) begin
            if (IDX >= slot_w) begin
               entries_in[i] = upper;
            end
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end

      assign entries[i] = entries_ff[i];
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.del) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule

// ----- rtl/plidm_tree.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plidm_tree
// registered reduction tree for the maximum and the addressed entry
// ----------------------------------------------------------------------------
module plidm_tree #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  logic                                clock,
   input  logic [plidm_pkg::DATA_W-1:0]        entries [CAPACITY],
   input  logic [CW-1:0]                       count,
   input  logic [plidm_pkg::SLOT_W-1:0]        slot,
   input  logic                                rd_en,
   output plidm_pkg::node_type                 root
);

   localparam int L = $clog2(CAPACITY);
   localparam int P = 1 << L;
   localparam int W = (CW > plidm_pkg::SLOT_W) ? CW : plidm_pkg::SLOT_W;

   plidm_pkg::node_type node_ff [1:P-1];
   plidm_pkg::node_type node_w  [1:2*P-1];

   for (genvar k = 1; k < P; k++) begin : g_node
      always_ff @(posedge clock) begin
         node_ff[k] <= plidm_pkg::node_merge(node_w[2*k], node_w[2*k+1]);
      end
      assign node_w[k] = node_ff[k];
   end

   for (genvar j = 0; j < P; j++) begin : g_leaf
      if (j < CAPACITY) begin : g_used
         logic sel;
         assign sel = rd_en && (W'(j) == W'(slot));
         assign node_w[P+j] = '{vld:  (CW'(j) < count),
                                maxv: entries[j],
                                rdv:  sel ? entries[j] : '0};
      end else begin : g_pad
         assign node_w[P+j] = '0;
      end
   end

   assign root = node_w[1];

endmodule

// ----- rtl/plidm_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plidm_dpath
// request register, position checks, cell chain, tree and response register
// ----------------------------------------------------------------------------
module plidm_dpath #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  plidm_pkg::ctrl_cmd_type               cmd,
   output plidm_pkg::dp_status_type              status,
   input  logic [plidm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic [plidm_pkg::OP_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [plidm_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int W  = (CW > plidm_pkg::SLOT_W) ? CW : plidm_pkg::SLOT_W;

   logic [plidm_pkg::OP_W-1:0]   op_ff;
   logic [plidm_pkg::DATA_W-1:0] value_ff;
   logic [plidm_pkg::SLOT_W-1:0] slot_ff;
   logic                         outcome_ff;
   logic                         rd_en_ff;
   logic                         rsp_valid_ff;
   logic [plidm_pkg::RSP_TDATA_W-1:0] rsp_data_ff;

   logic [plidm_pkg::DATA_W-1:0] entries [CAPACITY];
   logic [CW-1:0]                count;
   logic [W-1:0]                 count_w;
   logic [W-1:0]                 slot_w;
   logic                         is_ins;
   logic                         is_del;
   logic                         is_rd;
   logic                         ins_ok;
   logic                         pos_ok;
   logic                         op_ok;
   plidm_pkg::cell_cmd_type      cell_cmd;
   plidm_pkg::node_type          root;
   logic [plidm_pkg::DATA_W-1:0] largest;
   logic                         empty;

   assign count_w = W'(count);
   assign slot_w  = W'(slot_ff);
   assign is_ins  = (op_ff == plidm_pkg::OP_INSERT);
   assign is_del  = (op_ff == plidm_pkg::OP_DELETE);
   assign is_rd   = (op_ff == plidm_pkg::OP_READ);
   assign ins_ok  = (slot_w <= count_w) && (count_w < W'(CAPACITY));
   assign pos_ok  = (slot_w < count_w);
   assign op_ok   = (is_ins && ins_ok) || ((is_del || is_rd) && pos_ok);

   assign cell_cmd = '{ins:   cmd.exec && is_ins && ins_ok,
                       del:   cmd.exec && is_del && pos_ok,
                       slot:  slot_ff,
                       value: value_ff};

   plidm_cells #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_cells (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cell_cmd),
      .entries (entries),
      .count   (count)
   );

   plidm_tree #(
      .CAPACITY (CAPACITY),
      .CW       (CW)
   ) u_tree (
      .clock   (clock),
      .entries (entries),
      .count   (count),
      .slot    (slot_ff),
      .rd_en   (rd_en_ff),
      .root    (root)
   );

   // request capture and outcome of the executed op
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff    <= req_tuser;
         value_ff <= req_tdata[plidm_pkg::DATA_W-1:0];
         slot_ff  <= req_tdata[plidm_pkg::DATA_W +: plidm_pkg::SLOT_W];
      end
      if (cmd.exec) begin
         outcome_ff <= !op_ok;
         rd_en_ff   <= is_rd && pos_ok;
      end
   end

   assign empty   = (count_w == '0);
   assign largest = root.vld ? root.maxv : '1;

   // response register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff <= {7'd0, empty, largest, count_w[plidm_pkg::SLOT_W-1:0],
                         root.rdv, outcome_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_tdata       = rsp_data_ff;
   assign status.rsp_busy = rsp_valid_ff && !rsp_tready;

`ifndef SYNTHESIS
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      count_w <= W'(CAPACITY))
      else $error("fill count above capacity");

   a_insert_grows : assert property (@(posedge clock) disable iff (reset)
      cell_cmd.ins |=> (count_w == W'($past(count_w) + W'(1))))
      else $error("accepted insert did not grow the list");

   a_tree_matches_count : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (root.vld == (count_w != '0)))
      else $error("tree valid disagrees with fill count");
`endif

endmodule

// ----- rtl/plidm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plidm_ctrl
// sequencer: capture, execute, walk the tree levels, deliver the response
// ----------------------------------------------------------------------------
module plidm_ctrl #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  plidm_pkg::dp_status_type     status,
   output plidm_pkg::ctrl_cmd_type      cmd
);

   localparam int L    = $clog2(CAPACITY);
   localparam int CNTW = (L > 1) ? $clog2(L) : 1;

   plidm_pkg::state_type state_ff;
   plidm_pkg::state_type state_in;
   logic [CNTW-1:0]      cnt_ff;
   logic [CNTW-1:0]      cnt_in;
   logic                 sum_done;

   assign sum_done = (cnt_ff == CNTW'(L - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         plidm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = plidm_pkg::ST_EXEC;
            end
         end
         plidm_pkg::ST_EXEC: begin
            state_in = plidm_pkg::ST_SUM;
            cnt_in   = '0;
         end
         plidm_pkg::ST_SUM: begin
            if (sum_done) begin
               state_in = plidm_pkg::ST_FINISH;
            end else begin
               cnt_in = cnt_ff + CNTW'(1);
            end
         end
         plidm_pkg::ST_FINISH: begin
            if (!status.rsp_busy) begin
               state_in = plidm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = plidm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready   = 1'b0;
      cmd          = '0;
      case (state_ff)
         plidm_pkg::ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         plidm_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         plidm_pkg::ST_FINISH: begin
            cmd.load_rsp = !status.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plidm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- rtl/positional_list_insert_delete_max_unit.sv -----
// a request is captured, executed on the cell chain, carried up the registered
//    max / read tree one level per cycle, then loaded into the response register
// one request at a time: the next is accepted only once the response register is loaded
// insert and delete shift all cells at or above the slot together on the same clock edge
// reset: synchronous, clears fill count, sequencer and response valid; entries are not reset
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_max_unit
// ordered list with positional insert, delete and read, reporting the maximum
// ----------------------------------------------------------------------------
module positional_list_insert_delete_max_unit #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // item_value [31:0], slot [38:32]
   input  logic [plidm_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // op [1:0]
   input  logic [plidm_pkg::OP_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // outcome [0], read_value [32:1], fill_count [39:33], largest_value [71:40],
   // list_empty [72]
   output logic [plidm_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);

   plidm_pkg::ctrl_cmd_type  cmd;
   plidm_pkg::dp_status_type status;

   plidm_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   plidm_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- test/positional_list_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_checker
// watches the request and response channels of the positional list, keeps a
// shadow copy of the list, predicts every response and compares each field
// ----------------------------------------------------------------------------
module positional_list_checker #(
   parameter int CAPACITY = plidm_pkg::CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [plidm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [plidm_pkg::OP_W-1:0]        req_tuser,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [plidm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output int                                pending,
   output int                                failures
);
   import plidm_pkg::*;

   localparam int PRINT_LIMIT = 100;

   // packed from msb down, so it lines up with rsp_tdata from bit 0 up
   typedef struct packed {
      logic              list_empty;
      logic [DATA_W-1:0] largest_value;
      logic [SLOT_W-1:0] fill_count;
      logic [DATA_W-1:0] read_value;
      logic              outcome;
   } list_status_t;

   logic signed [DATA_W-1:0] shadow_list [CAPACITY];
   int                       shadow_fill;
   list_status_t             expected_status [$];
   int                       mismatch_total;

   assign failures = mismatch_total;

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      if (mismatch_total < PRINT_LIMIT) begin
         $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
      end
      mismatch_total++;
   endtask

   function automatic list_status_t apply_list_op(input logic [OP_W-1:0] op,
                                                  input logic [DATA_W-1:0] value,
                                                  input logic [SLOT_W-1:0] slot);
      list_status_t             st;
      int                       pos;
      logic signed [DATA_W-1:0] top;
      st = '0;
      st.outcome = 1'b1;
      pos = int'(slot);
      case (op)
         OP_INSERT: begin
            if (pos <= shadow_fill && shadow_fill < CAPACITY) begin
               for (int i = shadow_fill; i > pos; i--) begin
                  shadow_list[i] = shadow_list[i-1];
               end
               shadow_list[pos] = value;
               shadow_fill++;
               st.outcome = 1'b0;
            end
         end
         OP_DELETE: begin
            if (pos < shadow_fill) begin
               for (int i = pos; i + 1 < shadow_fill; i++) begin
                  shadow_list[i] = shadow_list[i+1];
               end
               shadow_fill--;
               st.outcome = 1'b0;
            end
         end
         OP_READ: begin
            if (pos < shadow_fill) begin
               st.read_value = shadow_list[pos];
               st.outcome = 1'b0;
            end
         end
         default: begin
         end
      endcase
      if (shadow_fill == 0) begin
         st.largest_value = '1;
      end else begin
         top = shadow_list[0];
         for (int i = 1; i < shadow_fill; i++) begin
            if (shadow_list[i] > top) begin
               top = shadow_list[i];
            end
         end
         st.largest_value = top;
      end
      st.fill_count = shadow_fill[SLOT_W-1:0];
      st.list_empty = (shadow_fill == 0);
      return st;
   endfunction

   always @(posedge clock) begin
      list_status_t got;
      list_status_t want;
      int           pushed;
      int           popped;
      pushed = 0;
      popped = 0;
      if (reset) begin
         shadow_fill = 0;
         expected_status.delete();
         pending <= 0;
      end else begin
         // responses first, so a stray one never matches a request of this edge
         if (rsp_tvalid && rsp_tready) begin
            got = list_status_t'(rsp_tdata[$bits(list_status_t)-1:0]);
            if (expected_status.size() == 0) begin
               report_mismatch("response with no request outstanding",
                               got.largest_value, '0);
            end else begin
               want = expected_status.pop_front();
               popped = 1;
               if (got.outcome !== want.outcome) begin
                  report_mismatch("outcome", DATA_W'(got.outcome), DATA_W'(want.outcome));
               end
               if (got.read_value !== want.read_value) begin
                  report_mismatch("read_value", got.read_value, want.read_value);
               end
               if (got.fill_count !== want.fill_count) begin
                  report_mismatch("fill_count", DATA_W'(got.fill_count),
                                  DATA_W'(want.fill_count));
               end
               if (got.largest_value !== want.largest_value) begin
                  report_mismatch("largest_value", got.largest_value, want.largest_value);
               end
               if (got.list_empty !== want.list_empty) begin
                  report_mismatch("list_empty", DATA_W'(got.list_empty),
                                  DATA_W'(want.list_empty));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_status.push_back(apply_list_op(req_tuser, req_tdata[DATA_W-1:0],
                                                    req_tdata[DATA_W+SLOT_W-1:DATA_W]));
            pushed = 1;
         end
         pending <= pending + pushed - popped;
      end
   end

endmodule

// ----- test/positional_list_insert_delete_max_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete_max_unit_tb
// drives insert, delete and read requests into the positional list: a short
// directed run over empty, edge and rejected cases, then fill and drain
// sequences with random values under several idle and stall mixes
// ----------------------------------------------------------------------------
module positional_list_insert_delete_max_unit_tb;
   import plidm_pkg::*;

   localparam int              CAPACITY         = CAPACITY_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED        = 2'd3;
   localparam int              RANDOM_PER_PHASE = 175;
   localparam int              PHASE_COUNT      = 4;
   localparam int              DRAIN_CYCLES     = 20;
   localparam int              CYCLE_LIMIT      = 400000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic [OP_W-1:0]        req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int pending;
   int failures;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int list_fill  = 0;
   int cycle_count = 0;

   positional_list_insert_delete_max_unit #(
      .CAPACITY(CAPACITY)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   positional_list_checker #(
      .CAPACITY(CAPACITY)
   ) list_check (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .pending   (pending),
      .failures  (failures)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value,
                               input logic [SLOT_W-1:0] slot);
      if ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {1'b0, slot, value};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // track the fill level so random slots stay mostly in range
      case (op)
         OP_INSERT: if (int'(slot) <= list_fill && list_fill < CAPACITY) list_fill++;
         OP_DELETE: if (int'(slot) < list_fill) list_fill--;
         default: begin
         end
      endcase
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic random_request(input int pos);
      logic [OP_W-1:0] op;
      int              roll;
      int              slot;
      logic            filling;
      filling = (pos < RANDOM_PER_PHASE * 5 / 8);
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         // noise: any op code, any slot
         op   = OP_W'($urandom_range(0, 3));
         slot = $urandom_range(0, 127);
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 75 : 10)) begin
            op = OP_INSERT;
         end else if (roll < (filling ? 82 : 75)) begin
            op = OP_DELETE;
         end else begin
            op = OP_READ;
         end
         if (op == OP_INSERT) begin
            slot = $urandom_range(0, list_fill);
         end else begin
            slot = (list_fill == 0) ? 0 : $urandom_range(0, list_fill - 1);
         end
      end
      send_request(op, pick_value(), SLOT_W'(slot));
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty list, bad positions and the unused op code
      send_request(OP_READ, 32'h1234_5678, 7'd0);
      send_request(OP_DELETE, 32'hffff_ffff, 7'd0);
      send_request(OP_INSERT, 32'd5, 7'd1);
      send_request(OP_UNUSED, 32'd9, 7'd0);
      // value extremes at front, end and middle
      send_request(OP_INSERT, 32'h7fff_ffff, 7'd0);
      send_request(OP_INSERT, 32'h8000_0000, 7'd0);
      send_request(OP_INSERT, 32'hffff_ffff, 7'd2);
      send_request(OP_INSERT, 32'h0000_0000, 7'd1);
      send_request(OP_INSERT, 32'h5a5a_5a5a, 7'd4);
      for (int i = 0; i < 5; i++) begin
         send_request(OP_READ, 32'hdead_beef, SLOT_W'(i));
      end
      send_request(OP_READ, 32'd0, 7'd5);
      send_request(OP_READ, 32'd0, 7'd64);
      send_request(OP_READ, 32'd0, 7'd127);
      send_request(OP_INSERT, 32'ha5a5_a5a5, 7'd64);
      // removing the current maximum
      send_request(OP_DELETE, 32'h1111_1111, 7'd2);
      send_request(OP_DELETE, 32'd0, 7'd4);
      send_request(OP_UNUSED, 32'hffff_ffff, 7'd127);
      repeat (4) send_request(OP_DELETE, 32'd0, 7'd0);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         wait_until_drained();
         case (ph)
            0: begin
               idle_pct = 0;
               stall_pct <= 0;
            end
            1: begin
               idle_pct = 73;
               stall_pct <= 0;
            end
            2: begin
               idle_pct = 0;
               stall_pct <= 73;
            end
            default: begin
               idle_pct = 34;
               stall_pct <= 34;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            random_request(n);
         end
      end

      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ----- positional_list_insert_delete_max_unit.f -----
rtl/plidm_pkg.sv
rtl/plidm_cells.sv
rtl/plidm_tree.sv
rtl/plidm_dpath.sv
rtl/plidm_ctrl.sv
rtl/positional_list_insert_delete_max_unit.sv
test/positional_list_checker.sv
test/positional_list_insert_delete_max_unit_tb.sv
